/* hdl/tkm_pkg.sv */
// shared types and constants of the top-k trimmed mean tracker
// no dependencies
package tkm_pkg;

   localparam int SampleWidth      = 16;
   localparam int CountWidth       = 6;
   localparam int KeepCountDefault = 32;
   localparam int TrimCountDefault = 4;
   localparam int CsrDataWidth     = 32;
   localparam int CsrAddrWidth     = 4;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REPLACE,
      CELL_ROTATE,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [SampleWidth-1:0] sample;
   } cell_cmd_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic [SampleWidth-1:0] value;
      logic                   gt;
      logic                   valid;
   } left_link_type;

   // handed from a cell to its left neighbor
   typedef struct packed {
      logic [SampleWidth-1:0] value;
      logic                   lt;
   } right_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      REG_BLACK_LEVEL    = 2'd0,
      REG_MIN_DELTA      = 2'd1,
      REG_CAPTURE_ENABLE = 2'd2
   } reg_index_type;

endpackage

/* hdl/tkm_if.sv */
// request and response channel interfaces of the tracker
// depends on tkm_pkg
interface tkm_req_if;
   import tkm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [SampleWidth-1:0] sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink (input valid, input mode, input sample, output ready);
endinterface

interface tkm_rsp_if;
   import tkm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SampleWidth-1:0] white_reference;
   logic [CountWidth-1:0]  kept_count;
   logic                   accepted;

   modport source (output valid, output white_reference, output kept_count,
                   output accepted, input ready);
   modport sink (input valid, input white_reference, input kept_count,
                 input accepted, output ready);
endinterface

/* hdl/tkm_cell.sv */
// one cell of the sorted store: holds a kept value and its valid bit
// depends on tkm_pkg
module tkm_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tkm_pkg::cell_cmd_type   cmd,
   input  tkm_pkg::left_link_type  left_in,
   input  tkm_pkg::right_link_type right_in,
   output tkm_pkg::left_link_type  left_out,
   output tkm_pkg::right_link_type right_out
);
   import tkm_pkg::*;

   logic [SampleWidth-1:0] value_ff;
   logic [SampleWidth-1:0] value_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic                   gt;
   logic                   lt;

   assign gt = !valid_ff || (value_ff > cmd.sample);
   assign lt = value_ff < cmd.sample;

   assign left_out.value  = value_ff;
   assign left_out.gt     = gt;
   assign left_out.valid  = valid_ff;
   assign right_out.value = value_ff;
   assign right_out.lt    = lt;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (gt) begin
               value_in = left_in.gt ? left_in.value : cmd.sample;
            end
            valid_in = valid_ff | left_in.valid;
         end
         CELL_REPLACE: begin
            if (right_in.lt) begin
               value_in = right_in.value;
            end else if (lt) begin
               value_in = cmd.sample;
            end
         end
         CELL_ROTATE: value_in = right_in.value;
         CELL_CLEAR:  valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* hdl/tkm_div.sv */
// iterative restoring divider, one quotient bit per cycle
// no dependencies
module tkm_div #(
   parameter int DividendWidth = 22,
   parameter int DivisorWidth  = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DividendWidth-1:0] dividend,
   input  logic [DivisorWidth-1:0]  divisor,
   output logic                     done,
   output logic [DividendWidth-1:0] quotient
);
   localparam int IterWidth = $clog2(DividendWidth + 1);

   logic [DividendWidth-1:0] quo_ff;
   logic [DividendWidth-1:0] quo_in;
   logic [DivisorWidth-1:0]  rem_ff;
   logic [DivisorWidth-1:0]  rem_in;
   logic [IterWidth-1:0]     iter_ff;
   logic [IterWidth-1:0]     iter_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic [DivisorWidth:0]    trial;
   logic [DivisorWidth:0]    diff;
   logic                     ge;

   assign trial    = {rem_ff, quo_ff[DividendWidth-1]};
   assign ge       = trial >= {1'b0, divisor};
   assign diff     = trial - {1'b0, divisor};
   assign done     = busy_ff && (iter_ff == IterWidth'(1));
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         iter_in = IterWidth'(DividendWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DividendWidth-2:0], ge};
         rem_in  = ge ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
         iter_in = iter_ff - IterWidth'(1);
         busy_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      iter_ff <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

/* hdl/top_k_trimmed_mean_tracker.sv */
// Keeps the KEEP_COUNT largest qualifying samples of one channel in a sorted
// row of cells and reports the rounded mean of them without the TRIM_COUNT
// largest (of all of them while no more than TRIM_COUNT are kept). One word
// is taken at a time: the store updates in the accept cycle, the kept values
// then circulate once through the row to be summed, and the divider then
// works out the quotient one bit at a time. The next word is taken while the
// previous result still waits in the output register.
// depends on tkm_pkg, tkm_if, tkm_cell, tkm_div
module top_k_trimmed_mean_tracker #(
   parameter int KEEP_COUNT = tkm_pkg::KeepCountDefault,
   parameter int TRIM_COUNT = tkm_pkg::TrimCountDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   tkm_req_if.sink                           req,
   tkm_rsp_if.source                         rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tkm_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [tkm_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [tkm_pkg::CsrDataWidth-1:0]  prdata,
   output logic                              pready
);
   import tkm_pkg::*;

   localparam int CntW  = $clog2(KEEP_COUNT + 1);
   localparam int StepW = $clog2(KEEP_COUNT);
   localparam int SumW  = 17 + $clog2(KEEP_COUNT);
   localparam int ExtW  = CntW + CountWidth;

   // configuration registers
   logic [SampleWidth-1:0] black_level_ff;
   logic [SampleWidth-1:0] min_delta_ff;
   logic                   capture_enable_ff;
   logic                   csr_write;
   reg_index_type          csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         REG_BLACK_LEVEL:    prdata = CsrDataWidth'(black_level_ff);
         REG_MIN_DELTA:      prdata = CsrDataWidth'(min_delta_ff);
         REG_CAPTURE_ENABLE: prdata = CsrDataWidth'(capture_enable_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_level_ff    <= '0;
         min_delta_ff      <= '0;
         capture_enable_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BLACK_LEVEL:    black_level_ff    <= pwdata[SampleWidth-1:0];
            REG_MIN_DELTA:      min_delta_ff      <= pwdata[SampleWidth-1:0];
            REG_CAPTURE_ENABLE: capture_enable_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // control
   ctrl_state_type         state_ff;
   ctrl_state_type         state_in;
   logic                   req_accept;
   logic                   load_out;
   logic                   div_start;
   logic                   div_done;
   logic [SumW-1:0]        quotient;
   logic                   last_step;
   logic [StepW-1:0]       step_ff;
   logic [StepW-1:0]       step_in;
   logic [SumW-1:0]        sum_ff;
   logic [SumW-1:0]        sum_in;
   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        count_in;
   logic [CntW-1:0]        used;
   logic [31:0]            count_wide32;
   logic                   acc_ff;
   logic                   acc_in;
   logic                   capture;
   logic                   full;
   cell_op_type            update_op;
   cell_cmd_type           cmd;
   left_link_type          lnk  [KEEP_COUNT+1];
   right_link_type         rlnk [KEEP_COUNT+1];

   logic                   rsp_valid_ff;
   logic [SampleWidth-1:0] white_ff;
   logic [CountWidth-1:0]  kept_ff;
   logic                   accepted_ff;
   logic [ExtW-1:0]        count_ext;

   assign full       = lnk[KEEP_COUNT].valid;
   assign capture    = !req.mode && capture_enable_ff &&
                       ({1'b0, req.sample} >= ({1'b0, black_level_ff} + {1'b0, min_delta_ff}));
   assign req_accept = req.valid && req.ready;
   assign last_step  = step_ff == StepW'(KEEP_COUNT - 1);

   assign count_wide32 = 32'(count_ff);
   assign used = (count_wide32 > 32'(TRIM_COUNT)) ? CntW'(count_wide32 - 32'(TRIM_COUNT))
                                                  : count_ff;

   always_comb begin
      if (req.mode) begin
         update_op = CELL_CLEAR;
      end else if (!capture) begin
         update_op = CELL_HOLD;
      end else if (!full) begin
         update_op = CELL_INSERT;
      end else if (rlnk[0].lt) begin
         update_op = CELL_REPLACE;
      end else begin
         update_op = CELL_HOLD;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_SUM;
         ST_SUM:  if (last_step) state_in = (used == '0) ? ST_OUT : ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req.ready  = 1'b0;
      cmd.op     = CELL_HOLD;
      cmd.sample = req.sample;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) cmd.op = update_op;
         end
         ST_SUM: begin
            cmd.op    = CELL_ROTATE;
            div_start = last_step && (used != '0);
         end
         ST_DIV: ;
         ST_OUT:  load_out = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   // kept count, step counter, running sum
   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      if (req_accept) begin
         step_in = '0;
         sum_in  = '0;
         acc_in  = (update_op == CELL_INSERT) || (update_op == CELL_REPLACE);
         if (update_op == CELL_CLEAR) begin
            count_in = '0;
         end else if (update_op == CELL_INSERT) begin
            count_in = count_ff + CntW'(1);
         end
      end else if (state_ff == ST_SUM) begin
         step_in = step_ff + StepW'(1);
         if (CntW'(step_ff) < used) begin
            sum_in = sum_ff + SumW'(rlnk[0].value);
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      sum_ff  <= sum_in;
      acc_ff  <= acc_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // row of cells
   assign lnk[0].value = '0;
   assign lnk[0].gt    = 1'b0;
   assign lnk[0].valid = 1'b1;
   assign rlnk[KEEP_COUNT].value = rlnk[0].value;
   assign rlnk[KEEP_COUNT].lt    = 1'b0;

   for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
      tkm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .left_in   (lnk[i]),
         .right_in  (rlnk[i+1]),
         .left_out  (lnk[i+1]),
         .right_out (rlnk[i])
      );
   end

   tkm_div #(
      .DividendWidth (SumW),
      .DivisorWidth  (CntW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in + SumW'(used >> 1)),
      .divisor  (used),
      .done     (div_done),
      .quotient (quotient)
   );

   // output register
   assign count_ext = ExtW'(count_ff);

   always_ff @(posedge clock) begin
      if (load_out) begin
         white_ff    <= (used == '0) ? black_level_ff : quotient[SampleWidth-1:0];
         kept_ff     <= count_ext[CountWidth-1:0];
         accepted_ff <= acc_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.white_reference = white_ff;
   assign rsp.kept_count      = kept_ff;
   assign rsp.accepted        = accepted_ff;

endmodule
